// File: design/pbws_pkg.sv
// pbws_pkg: shared types and codes for the protobuf wire field scanner
// holds the scanner state record, the result record and the phase/kind/error codes
// no dependencies
`timescale 1ns / 1ps

package pbws_pkg;

  // scan phases
  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_FIXED   = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_LEN_HDR = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_FIX_HDR = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERLONG  = 2'd1;
  localparam logic [1:0] ERR_WIRE_TYPE = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // varint limits
  localparam logic [3:0] VARINT_LAST_IDX  = 4'd9;
  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam logic [5:0] VARINT_GROUP     = 6'd7;

  localparam logic [63:0] FIXED64_BYTES = 64'd8;
  localparam logic [63:0] FIXED32_BYTES = 64'd4;

  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] acc;
    logic [3:0]  cnt;
    logic [31:0] field;
    logic [2:0]  wire_t;
    logic [63:0] bytes_left;
    logic        discarding;
  } scan_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fld_num;
    logic [2:0]  wire_type;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        message_done;
  } scan_result_t;

  localparam scan_state_t SCAN_RESET = '{default: '0};

endpackage

// File: design/protobuf_wire_field_scanner.sv
// protobuf_wire_field_scanner: top level of the byte-serial protobuf field scanner
// depends on pbws_pkg and pbws_decode
`timescale 1ns / 1ps

// usage
//   in_*  : one message byte per beat, in_tlast marks the last byte of a message
//   out_* : at most one result beat per input beat; out_tuser is the result kind,
//           out_tlast is set when the result came from the last message byte
//   each accepted byte updates the scan state (tag/varint accumulator, phase,
//   remaining payload count) in the same cycle it is taken
//   a result goes to the output register, or to the skid register if that one waits
//   throughput: one byte per cycle while in_tready is high, set by the combinational
//   decode between the scan state registers and the output register
//   stall: a two-entry output stage (output register plus skid register) keeps
//   in_tready high while one result waits; in_tready drops only when both
//   entries are full
//   reset: rst_n low clears the scan state to "expect tag" and empties the
//   output stage; the first byte after reset is taken as the start of a message
//   after an error, bytes are dropped without results up to and including the
//   last byte of that message

module protobuf_wire_field_scanner (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] fld_num, [34:32] wire_type, [98:35] field_value,
  // [106:99] payload_byte, [108:107] error_code, [111:109] zero
  output logic [111:0] out_tdata,
  output logic [2:0]   out_tuser,  // [2:0] kind
  output logic         out_tlast   // message_done
);
  import pbws_pkg::*;

  scan_state_t  st_r, st_nxt;
  scan_result_t res;
  logic         res_vld;
  logic         in_fire;
  logic         out_fire;

  scan_result_t out_res_r;
  logic         out_vld_r;
  scan_result_t skid_res_r;
  logic         skid_vld_r;

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_vld_r && out_tready;

  pbws_decode u_decode (
    .st        (st_r),
    .data_byte (in_tdata),
    .eom       (in_tlast),
    .st_nxt    (st_nxt),
    .res       (res),
    .res_vld   (res_vld)
  );

  // scan state advances once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_RESET;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_fire) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= in_fire && res_vld;
        end
      end else if (in_fire && res_vld) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_fire) begin
      if (skid_vld_r) begin
        out_res_r <= skid_res_r;
      end else if (in_fire && res_vld) begin
        out_res_r <= res;
      end
    end else if (in_fire && res_vld) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_res_r.error_code, out_res_r.payload_byte,
                       out_res_r.field_value, out_res_r.wire_type, out_res_r.fld_num};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.message_done;

`ifndef SYNTHESIS
  // the skid entry only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid with empty output register");

  // error code is set exactly on error results
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((out_res_r.kind == KIND_ERROR) == (out_res_r.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // the last byte of a message always leaves the scanner expecting a fresh tag
  a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (st_r.phase == PH_TAG && !st_r.discarding &&
                               st_r.cnt == 4'd0))
    else $error("scan state not restarted after last message byte");

  // discarding produces no results
  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st_r.discarding) |-> !res_vld)
    else $error("result produced while discarding");
`endif

endmodule

// File: design/pbws_decode.sv
// pbws_decode: next-state and result logic for one message byte
// depends on pbws_pkg for the state and result records
`timescale 1ns / 1ps

module pbws_decode (
  input  pbws_pkg::scan_state_t  st,
  input  logic [7:0]             data_byte,
  input  logic                   eom,
  output pbws_pkg::scan_state_t  st_nxt,
  output pbws_pkg::scan_result_t res,
  output logic                   res_vld
);
  import pbws_pkg::*;

  logic [3:0]  cnt_sat;
  logic [5:0]  sh;
  logic [63:0] acc_new;
  logic [3:0]  cnt_new;
  logic        vi_done;
  logic        vi_over;
  logic        err;
  logic [63:0] left_dec;
  logic [2:0]  tag_wire;

  always_comb begin
    cnt_sat  = (st.cnt > VARINT_LAST_IDX) ? VARINT_LAST_IDX : st.cnt;
    sh       = 6'({2'b00, cnt_sat} * VARINT_GROUP);
    acc_new  = st.acc | (64'(data_byte[6:0]) << sh);
    cnt_new  = cnt_sat + 4'd1;
    vi_done  = !data_byte[7];
    vi_over  = data_byte[7] && (cnt_new >= VARINT_MAX_BYTES);
    left_dec = (st.bytes_left != 64'd0) ? st.bytes_left - 64'd1 : st.bytes_left;
    tag_wire = acc_new[2:0];
  end

  always_comb begin
    st_nxt  = st;
    res     = '0;
    res_vld = 1'b0;
    err     = 1'b0;
    if (st.discarding) begin
      if (eom) begin
        st_nxt = SCAN_RESET;
      end
    end else begin
      case (st.phase)
        PH_VALUE, PH_LENGTH: begin
          st_nxt.acc = acc_new;
          st_nxt.cnt = cnt_new;
          if (vi_over) begin
            res.kind       = KIND_ERROR;
            res.fld_num    = st.field;
            res.wire_type  = st.wire_t;
            res.error_code = ERR_OVERLONG;
            err            = 1'b1;
          end else if (vi_done) begin
            st_nxt.acc      = '0;
            st_nxt.cnt      = '0;
            res.fld_num     = st.field;
            res.wire_type   = st.wire_t;
            res.field_value = acc_new;
            res_vld         = 1'b1;
            if (st.phase == PH_VALUE) begin
              res.kind     = KIND_VARINT;
              st_nxt.phase = PH_TAG;
            end else begin
              res.kind          = KIND_LEN_HDR;
              st_nxt.bytes_left = acc_new;
              st_nxt.phase      = (acc_new != 64'd0) ? PH_PAYLOAD : PH_TAG;
            end
          end
        end
        PH_PAYLOAD, PH_FIXED: begin
          res.kind          = KIND_PAYLOAD;
          res.fld_num       = st.field;
          res.wire_type     = st.wire_t;
          res.payload_byte  = data_byte;
          res_vld           = 1'b1;
          st_nxt.bytes_left = left_dec;
          if (left_dec == 64'd0) begin
            st_nxt.phase = PH_TAG;
          end
        end
        default: begin
          st_nxt.acc = acc_new;
          st_nxt.cnt = cnt_new;
          if (vi_over) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_OVERLONG;
            err            = 1'b1;
          end else if (vi_done) begin
            st_nxt.field  = acc_new[34:3];
            st_nxt.wire_t = tag_wire;
            st_nxt.acc    = '0;
            st_nxt.cnt    = '0;
            case (tag_wire)
              WT_VARINT: st_nxt.phase = PH_VALUE;
              WT_LEN:    st_nxt.phase = PH_LENGTH;
              WT_FIXED64, WT_FIXED32: begin
                st_nxt.bytes_left = (tag_wire == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
                st_nxt.phase      = PH_FIXED;
                res.kind          = KIND_FIX_HDR;
                res.fld_num       = acc_new[34:3];
                res.wire_type     = tag_wire;
                res.field_value   = (tag_wire == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
                res_vld           = 1'b1;
              end
              default: begin
                res.kind       = KIND_ERROR;
                res.fld_num    = acc_new[34:3];
                res.wire_type  = tag_wire;
                res.error_code = ERR_WIRE_TYPE;
                err            = 1'b1;
              end
            endcase
          end
        end
      endcase

      if (err) begin
        res_vld           = 1'b1;
        st_nxt.phase      = PH_TAG;
        st_nxt.acc        = '0;
        st_nxt.cnt        = '0;
        st_nxt.bytes_left = '0;
        st_nxt.discarding = 1'b1;
      end

      if (eom) begin
        // field, tag or length left open by the last byte
        if (!err && (st_nxt.phase != PH_TAG || st_nxt.cnt != 4'd0)) begin
          res            = '0;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
          if (st_nxt.phase != PH_TAG) begin
            res.fld_num   = st_nxt.field;
            res.wire_type = st_nxt.wire_t;
          end
          res_vld = 1'b1;
        end
        res.message_done = res_vld;
        st_nxt           = SCAN_RESET;
      end
    end
  end

endmodule

// File: dv/protobuf_wire_field_scanner_tb.sv
// protobuf_wire_field_scanner_tb: self-checking bench for the protobuf wire field scanner
// keeps its own byte-level decoder state, predicts each result beat and compares field by field
// depends on pbws_pkg and protobuf_wire_field_scanner
`timescale 1ns / 1ps

module protobuf_wire_field_scanner_tb;
  import pbws_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 2;
  localparam int ITEM_TARGET  = 1900;
  localparam int RX_HOLD      = 40;
  localparam int DRAIN_SETTLE = 2;
  localparam int END_SETTLE   = 8;
  // far beyond the slowest legal run
  localparam int TIMEOUT_NS   = 300000 * 2 * CLK_HALF;

  // wire types the scanner rejects
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_RESV6  = 3'd6;
  localparam logic [2:0] WT_RESV7  = 3'd7;

  typedef enum {VI_MORE, VI_DONE, VI_OVERLONG} varint_step_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  protobuf_wire_field_scanner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // decoder state mirror and expected result beats
  // ---------------------------------------------------------------------------
  logic [2:0]   sc_phase;
  logic [63:0]  sc_acc;
  logic [3:0]   sc_cnt;
  logic [31:0]  sc_field;
  logic [2:0]   sc_wire;
  logic [63:0]  sc_left;
  bit           sc_drop;

  scan_result_t expected_results[$];
  int           mismatches    = 0;
  int           scanned_bytes = 0;

  // bench-side control of both handshakes
  bit           steady_tx     = 1'b0;
  bit           steady_rx     = 1'b0;
  int           rx_hold_cycles = 0;

  logic [7:0]   msg_bytes[$];

  function automatic void add_msg_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  function automatic void clear_scan();
    sc_phase = PH_TAG;
    sc_acc   = '0;
    sc_cnt   = '0;
    sc_field = '0;
    sc_wire  = '0;
    sc_left  = '0;
    sc_drop  = 1'b0;
  endfunction

  // the tenth group only adds bit 63
  function automatic varint_step_t take_varint_group(input logic [7:0] b);
    logic [3:0] n;
    n = (sc_cnt > VARINT_LAST_IDX) ? VARINT_LAST_IDX : sc_cnt;
    sc_acc |= {57'd0, b[6:0]} << (7 * n);
    sc_cnt = n + 4'd1;
    if (!b[7]) return VI_DONE;
    return (sc_cnt >= VARINT_MAX_BYTES) ? VI_OVERLONG : VI_MORE;
  endfunction

  function automatic scan_result_t make_result(input logic [2:0] kind, input logic [31:0] field,
                                               input logic [2:0] wire_t, input logic [63:0] value,
                                               input logic [7:0] pbyte, input logic [1:0] err);
    scan_result_t r;
    r              = '0;
    r.kind         = kind;
    r.fld_num      = field;
    r.wire_type    = wire_t;
    r.field_value  = value;
    r.payload_byte = pbyte;
    r.error_code   = err;
    return r;
  endfunction

  // advance the mirror by one accepted byte; returns 0 for a byte dropped after an error
  function automatic bit decode_byte(input logic [7:0] b, input logic eom);
    scan_result_t r;
    bit           got;
    bit           err;
    varint_step_t vs;
    logic [63:0]  v;
    r   = '0;
    got = 1'b0;
    err = 1'b0;
    if (sc_drop) begin
      if (eom) clear_scan();
      return 1'b0;
    end
    case (sc_phase)
      PH_VALUE, PH_LENGTH: begin
        vs = take_varint_group(b);
        if (vs == VI_OVERLONG) begin
          r   = make_result(KIND_ERROR, sc_field, sc_wire, '0, '0, ERR_OVERLONG);
          err = 1'b1;
        end else if (vs == VI_DONE) begin
          v      = sc_acc;
          sc_acc = '0;
          sc_cnt = '0;
          got    = 1'b1;
          if (sc_phase == PH_VALUE) begin
            r        = make_result(KIND_VARINT, sc_field, sc_wire, v, '0, ERR_NONE);
            sc_phase = PH_TAG;
          end else begin
            r        = make_result(KIND_LEN_HDR, sc_field, sc_wire, v, '0, ERR_NONE);
            sc_left  = v;
            sc_phase = (v != 0) ? PH_PAYLOAD : PH_TAG;
          end
        end
      end
      PH_PAYLOAD, PH_FIXED: begin
        r   = make_result(KIND_PAYLOAD, sc_field, sc_wire, '0, b, ERR_NONE);
        got = 1'b1;
        if (sc_left != 0) sc_left = sc_left - 1;
        if (sc_left == 0) sc_phase = PH_TAG;
      end
      default: begin
        vs = take_varint_group(b);
        if (vs == VI_OVERLONG) begin
          r   = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_OVERLONG);
          err = 1'b1;
        end else if (vs == VI_DONE) begin
          sc_field = sc_acc[34:3];
          sc_wire  = sc_acc[2:0];
          sc_acc   = '0;
          sc_cnt   = '0;
          case (sc_wire)
            WT_VARINT: sc_phase = PH_VALUE;
            WT_LEN:    sc_phase = PH_LENGTH;
            WT_FIXED64, WT_FIXED32: begin
              sc_left  = (sc_wire == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
              r        = make_result(KIND_FIX_HDR, sc_field, sc_wire, sc_left, '0, ERR_NONE);
              got      = 1'b1;
              sc_phase = PH_FIXED;
            end
            default: begin
              r   = make_result(KIND_ERROR, sc_field, sc_wire, '0, '0, ERR_WIRE_TYPE);
              err = 1'b1;
            end
          endcase
        end
      end
    endcase
    if (err) begin
      got      = 1'b1;
      sc_phase = PH_TAG;
      sc_acc   = '0;
      sc_cnt   = '0;
      sc_left  = '0;
      sc_drop  = 1'b1;
    end
    if (eom) begin
      // an unfinished tag, length or field replaces this byte's own result
      if (!err && (sc_phase != PH_TAG || sc_cnt != 0)) begin
        if (sc_phase == PH_TAG)
          r = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_TRUNCATED);
        else
          r = make_result(KIND_ERROR, sc_field, sc_wire, '0, '0, ERR_TRUNCATED);
        got = 1'b1;
      end
      r.message_done = got;
      clear_scan();
    end
    if (got) expected_results.insert(expected_results.size(), r);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // message building
  // ---------------------------------------------------------------------------
  // min_len above the minimal size pads with continuation groups
  function automatic void put_varint(input logic [63:0] v, input int min_len);
    logic [6:0] grp;
    bit         stop;
    for (int i = 0; i < 10; i++) begin
      grp  = v[6:0];
      v    = v >> 7;
      stop = (v == 0 && i + 1 >= min_len) || i == 9;
      // upper bits of the tenth group are junk the scanner must ignore
      if (i == 9) grp[6:1] = 6'($urandom);
      add_msg_byte({!stop, grp});
      if (stop) break;
    end
  endfunction

  function automatic int pad_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 1;
  endfunction

  function automatic void put_tag(input logic [60:0] fnum, input logic [2:0] wire_t);
    put_varint({fnum, wire_t}, pad_len());
  endfunction

  function automatic void put_payload(input int n);
    repeat (n) add_msg_byte(8'($urandom));
  endfunction

  function automatic logic [63:0] random_value();
    int          nbits;
    logic [63:0] v;
    v     = {$urandom, $urandom};
    nbits = $urandom_range(0, 64);
    if ($urandom_range(0, 15) == 0) return '1;
    if (nbits < 64) v &= (64'd1 << nbits) - 64'd1;
    return v;
  endfunction

  // mostly well-formed fields, with bad wire types, overlong varints,
  // runaway lengths and cut-short messages mixed in
  function automatic void build_random_message();
    int          pick;
    int          len;
    logic [63:0] raw;
    logic [60:0] fnum;
    repeat ($urandom_range(1, 5)) begin
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 60)      fnum = 61'($urandom_range(0, 31));
      else if (pick < 80) fnum = 61'($urandom_range(0, 1 << 28));
      else if (pick < 95) fnum = {29'd0, raw[31:0]};
      else                fnum = raw[60:0];
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        put_tag(fnum, WT_VARINT);
        put_varint(random_value(), pad_len());
      end else if (pick < 55) begin
        len = $urandom_range(0, 6);
        put_tag(fnum, WT_LEN);
        put_varint(64'(len), pad_len());
        put_payload(len);
      end else if (pick < 65) begin
        put_tag(fnum, WT_FIXED64);
        put_payload(8);
      end else if (pick < 75) begin
        put_tag(fnum, WT_FIXED32);
        put_payload(4);
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0:       put_tag(fnum, WT_SGROUP);
          1:       put_tag(fnum, WT_EGROUP);
          2:       put_tag(fnum, WT_RESV6);
          default: put_tag(fnum, WT_RESV7);
        endcase
      end else if (pick < 84) begin
        // overlong varint, either the tag itself or a value
        if ($urandom_range(0, 1)) put_tag(fnum, WT_VARINT);
        repeat ($urandom_range(10, 12)) add_msg_byte(8'h80 | 8'($urandom));
      end else if (pick < 87) begin
        // length that runs past the end of the message
        put_tag(fnum, WT_LEN);
        put_varint(random_value() | 64'h100, 1);
      end else begin
        put_tag(fnum, WT_VARINT);
        put_varint(random_value(), $urandom_range(1, 10));
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      len = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    void'(decode_byte(b, last));
    scanned_bytes++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  // sender pauses until every predicted beat has come out
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    out_tready = 1'b0;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = steady_rx ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // every result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing predicted, kind %0d", out_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind",         64'(want.kind),         64'(out_tuser));
        check_field("fld_num",      64'(want.fld_num),      64'(out_tdata[31:0]));
        check_field("wire_type",    64'(want.wire_type),    64'(out_tdata[34:32]));
        check_field("field_value",  want.field_value,       out_tdata[98:35]);
        check_field("payload_byte", 64'(want.payload_byte), 64'(out_tdata[106:99]));
        check_field("error_code",   64'(want.error_code),   64'(out_tdata[108:107]));
        check_field("message_done", 64'(want.message_done), 64'(out_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // varint, length header with payload, fixed32, zero length on the last byte
  task automatic test_field_kinds();
    msg_bytes = '{8'h08, 8'h96, 8'h01,
                  8'h12, 8'h01, 8'hFF,
                  8'h1D, 8'h00, 8'h11, 8'h22, 8'h80,
                  8'h2A, 8'h00};
    send_message();
    wait_results_drained();
  endtask

  // group-start wire type, then the rest of the message is dropped
  task automatic test_bad_wire_type();
    msg_bytes = '{8'h0B, 8'hFF, 8'h00};
    send_message();
    wait_results_drained();
  endtask

  // payload longer than the message, then a message that ends inside a tag
  task automatic test_truncated_message();
    msg_bytes = '{8'h12, 8'h05, 8'hAA};
    send_message();
    msg_bytes = '{8'hFF};
    send_message();
    wait_results_drained();
  endtask

  // tenth tag byte still continues and is also the last byte
  task automatic test_overlong_varint();
    repeat (10) add_msg_byte(8'hFF);
    send_message();
    wait_results_drained();
  endtask

  // receiver stops for a long stretch while bytes keep coming
  task automatic test_backpressure();
    steady_tx      = 1'b1;
    rx_hold_cycles = RX_HOLD;
    put_tag(61'd7, WT_LEN);
    put_varint(64'd24, 1);
    put_payload(24);
    send_message();
    steady_tx = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_messages();
    while (scanned_bytes < ITEM_TARGET) begin
      // occasional stretches without idle cycles on either side
      steady_tx = ($urandom_range(0, 7) == 0);
      steady_rx = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 8)) add_msg_byte(8'($urandom));
      else
        build_random_message();
      send_message();
      if ($urandom_range(0, 9) == 0) wait_results_drained();
    end
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  initial begin : sequencer
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_field_kinds();
    test_bad_wire_type();
    test_truncated_message();
    test_overlong_varint();
    test_backpressure();
    test_random_messages();

    wait_results_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("protobuf_wire_field_scanner regression: pass");
    else
      $display("protobuf_wire_field_scanner regression: fail");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("protobuf_wire_field_scanner regression: fail");
    $finish;
  end

endmodule
